@@ sv/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros shared by the supply monitor RTL
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted (active-low reset).
`define ASW_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define ASW_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/asw_pkg.sv @@
// ---------------------------------------------------------------------------
// asw_pkg
// Types and constants of the averaged supply window monitor.
// ---------------------------------------------------------------------------
package asw_pkg;

    // Window depth; a power of two so the average is a plain shift.
    localparam int DEPTH       = 16;
    localparam int SAMPLE_BITS = 12;
    localparam int CHANNELS    = 4;
    localparam int DEPTH_LOG2  = $clog2(DEPTH);
    localparam int SLOT_W      = DEPTH_LOG2;
    localparam int SUM_W       = SAMPLE_BITS + DEPTH_LOG2;
    localparam int AVG_W       = 12;
    localparam int REG_W       = 12;
    localparam int POWER_W     = 24;
    localparam int CFG_IDX_W   = 3;

    // Channel positions inside one sample set
    localparam int CH_ARRAY_V   = 0;
    localparam int CH_ARRAY_I   = 1;
    localparam int CH_BATTERY_V = 2;
    localparam int CH_BATTERY_I = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ARRAY_ON_LEVEL   = 3'd0,
        CFG_ARRAY_OFF_LEVEL  = 3'd1,
        CFG_BATTERY_ON_LOW   = 3'd2,
        CFG_BATTERY_ON_HIGH  = 3'd3,
        CFG_BATTERY_OFF_LOW  = 3'd4,
        CFG_BATTERY_OFF_HIGH = 3'd5
    } t_cfg_idx;

    localparam logic [REG_W-1:0] RST_ARRAY_ON_LEVEL   = 12'd816;
    localparam logic [REG_W-1:0] RST_ARRAY_OFF_LEVEL  = 12'd512;
    localparam logic [REG_W-1:0] RST_BATTERY_ON_LOW   = 12'd350;
    localparam logic [REG_W-1:0] RST_BATTERY_ON_HIGH  = 12'd1750;
    localparam logic [REG_W-1:0] RST_BATTERY_OFF_LOW  = 12'd318;
    localparam logic [REG_W-1:0] RST_BATTERY_OFF_HIGH = 12'd1783;

    typedef logic [SAMPLE_BITS-1:0]           t_sample;
    typedef t_sample [CHANNELS-1:0]           t_set;
    typedef logic [SUM_W-1:0]                 t_sum;
    typedef logic [AVG_W-1:0]                 t_avg;
    typedef logic [SLOT_W-1:0]                t_slot;

    typedef struct packed {
        logic [11:0] array_voltage_sample;
        logic [11:0] array_current_sample;
        logic [11:0] battery_voltage_sample;
        logic [11:0] battery_current_sample;
    } t_in_item;

    typedef struct packed {
        logic [11:0]        avg_array_voltage;
        logic [11:0]        avg_array_current;
        logic [11:0]        avg_battery_voltage;
        logic [11:0]        avg_battery_current;
        logic               array_good;
        logic               battery_good;
        logic               fault_led;
        logic               run_led;
        logic               pwm_enable;
        logic [POWER_W-1:0] input_power;
    } t_out_item;

endpackage

@@ sv/asw_ring.sv @@
// ---------------------------------------------------------------------------
// asw_ring
// Ring of the last DEPTH sample sets: one synchronous RAM, read-first,
// with a valid bit per entry so unwritten entries read as zero.
// ---------------------------------------------------------------------------
module asw_ring
    import asw_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr,        // store a new set, fetch the one it replaces
    input  t_set i_wr_data,
    output t_set o_old        // replaced set, valid the cycle after i_wr
);

    localparam t_slot SLOT_LAST = t_slot'(DEPTH - 1);

    t_set              r_mem [DEPTH];
    t_set              r_rd_data;
    logic              r_rd_vld;
    logic [DEPTH-1:0]  r_valid;
    t_slot             r_slot;
    t_slot             n_slot;

    always_comb begin
        n_slot = (r_slot == SLOT_LAST) ? '0 : r_slot + 1'b1;
    end

    // Memory port: read-first, then overwrite the same slot
    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_rd_data       <= r_mem[r_slot];
            r_rd_vld        <= r_valid[r_slot];
            r_mem[r_slot]   <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_slot  <= '0;
        end else if (i_wr) begin
            r_valid[r_slot] <= 1'b1;
            r_slot          <= n_slot;
        end
    end

    assign o_old = r_rd_vld ? r_rd_data : '0;

`include "assert_macros.svh"

    `ASW_ASSERT(a_slot_step, i_clk, i_rst_n, (i_wr && r_slot != SLOT_LAST) |=> (r_slot == $past(r_slot) + 1'b1), "ring slot did not advance")
    `ASW_ASSERT(a_slot_wrap, i_clk, i_rst_n, (i_wr && r_slot == SLOT_LAST) |=> (r_slot == '0), "ring slot did not wrap")
    `ASW_ASSERT(a_slot_hold, i_clk, i_rst_n, !i_wr |=> $stable(r_slot), "ring slot moved without a write")

endmodule

@@ sv/averaged_supply_window_monitor_unit.sv @@
// ---------------------------------------------------------------------------
// averaged_supply_window_monitor_unit
// Moving average of four ADC channels with hysteresis supervision of the
// array and battery voltages, status LEDs, PWM enable and input power.
// ---------------------------------------------------------------------------
//
//  channel | handshake                 | payload
//  --------+---------------------------+-----------------------------
//  in      | i_in_valid / o_in_ready   | i_in_item  (t_in_item)
//  out     | o_out_valid / i_out_ready | o_out_item (t_out_item)
//  config  | i_cfg_we (no wait)        | i_cfg_index, i_cfg_data
//
// One item per cycle sustained while the output is not stalled; an accepted
// item passes stage A, stage B and the output stage in turn. Stage A holds
// the new set and the replaced set read from the ring RAM, stage B updates the
// running sums and both statuses, the output stage forms the 12x12 power
// product.
// Each stage advances when the stage after it is empty or moving, so a
// stalled output still lets up to two more items in.
// Synchronous active-low reset clears the ring valid bits, sums, statuses and
// stage valid bits and loads the default thresholds; no clearing pass is needed.
// ---------------------------------------------------------------------------
module averaged_supply_window_monitor_unit
    import asw_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_item             i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_item            o_out_item,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [REG_W-1:0]     i_cfg_data
);

    // Threshold registers
    logic [REG_W-1:0] r_array_on_level;
    logic [REG_W-1:0] r_array_off_level;
    logic [REG_W-1:0] r_battery_on_low;
    logic [REG_W-1:0] r_battery_on_high;
    logic [REG_W-1:0] r_battery_off_low;
    logic [REG_W-1:0] r_battery_off_high;

    // Pipeline control
    logic r_a_vld, r_b_vld, r_o_vld;
    logic en_a, en_b, en_o;
    logic in_acc;

    // Stage A payload and the replaced set from the ring
    t_set w_new_set;
    t_set r_a_new;
    t_set w_old_set;

    // Running state
    t_sum r_sum [CHANNELS];
    t_sum n_sum [CHANNELS];
    t_avg n_avg [CHANNELS];
    logic r_array_stat, r_battery_stat;
    logic n_array_stat, n_battery_stat;

    // Stage B payload
    t_avg r_b_avg [CHANNELS];
    logic r_b_array_stat, r_b_battery_stat;

    t_out_item r_out;
    t_out_item n_out;

    // Advance a stage when the next one is empty or moving
    assign en_o       = !r_o_vld || i_out_ready;
    assign en_b       = !r_b_vld || en_o;
    assign en_a       = !r_a_vld || en_b;
    assign o_in_ready = en_a;
    assign in_acc     = i_in_valid && en_a;

    // Mask or extend each raw sample to SAMPLE_BITS
    assign w_new_set[CH_ARRAY_V]   = t_sample'(i_in_item.array_voltage_sample);
    assign w_new_set[CH_ARRAY_I]   = t_sample'(i_in_item.array_current_sample);
    assign w_new_set[CH_BATTERY_V] = t_sample'(i_in_item.battery_voltage_sample);
    assign w_new_set[CH_BATTERY_I] = t_sample'(i_in_item.battery_current_sample);

    asw_ring u_ring (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (in_acc),
        .i_wr_data (w_new_set),
        .o_old     (w_old_set)
    );

    // Configuration writes; indexes beyond the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_array_on_level   <= RST_ARRAY_ON_LEVEL;
            r_array_off_level  <= RST_ARRAY_OFF_LEVEL;
            r_battery_on_low   <= RST_BATTERY_ON_LOW;
            r_battery_on_high  <= RST_BATTERY_ON_HIGH;
            r_battery_off_low  <= RST_BATTERY_OFF_LOW;
            r_battery_off_high <= RST_BATTERY_OFF_HIGH;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ARRAY_ON_LEVEL:   r_array_on_level   <= i_cfg_data;
                CFG_ARRAY_OFF_LEVEL:  r_array_off_level  <= i_cfg_data;
                CFG_BATTERY_ON_LOW:   r_battery_on_low   <= i_cfg_data;
                CFG_BATTERY_ON_HIGH:  r_battery_on_high  <= i_cfg_data;
                CFG_BATTERY_OFF_LOW:  r_battery_off_low  <= i_cfg_data;
                CFG_BATTERY_OFF_HIGH: r_battery_off_high <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Stage B: running sums, averages and hysteresis
    always_comb begin
        for (int c = 0; c < CHANNELS; c++) begin
            n_sum[c] = r_sum[c] - t_sum'(w_old_set[c]) + t_sum'(r_a_new[c]);
            n_avg[c] = t_avg'(n_sum[c] >> DEPTH_LOG2);
        end
        // Array: on level to recover, off level to drop
        if (r_array_stat) begin
            n_array_stat = (n_avg[CH_ARRAY_V] >= r_array_off_level);
        end else begin
            n_array_stat = (n_avg[CH_ARRAY_V] >= r_array_on_level);
        end
        // Battery: narrower on window inside a wider off window
        if (r_battery_stat) begin
            n_battery_stat = (n_avg[CH_BATTERY_V] >= r_battery_off_low) &&
                             (n_avg[CH_BATTERY_V] <= r_battery_off_high);
        end else begin
            n_battery_stat = (n_avg[CH_BATTERY_V] >= r_battery_on_low) &&
                             (n_avg[CH_BATTERY_V] <= r_battery_on_high);
        end
    end

    // Output stage: combine statuses and form the power product
    always_comb begin
        n_out.avg_array_voltage   = r_b_avg[CH_ARRAY_V];
        n_out.avg_array_current   = r_b_avg[CH_ARRAY_I];
        n_out.avg_battery_voltage = r_b_avg[CH_BATTERY_V];
        n_out.avg_battery_current = r_b_avg[CH_BATTERY_I];
        n_out.array_good          = r_b_array_stat;
        n_out.battery_good        = r_b_battery_stat;
        n_out.run_led             = r_b_array_stat && r_b_battery_stat;
        n_out.pwm_enable          = r_b_array_stat && r_b_battery_stat;
        n_out.fault_led           = !(r_b_array_stat && r_b_battery_stat);
        n_out.input_power         = POWER_W'(r_b_avg[CH_ARRAY_I]) *
                                    POWER_W'(r_b_avg[CH_ARRAY_V]);
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld        <= 1'b0;
            r_b_vld        <= 1'b0;
            r_o_vld        <= 1'b0;
            r_array_stat   <= 1'b0;
            r_battery_stat <= 1'b0;
            for (int c = 0; c < CHANNELS; c++) begin
                r_sum[c] <= '0;
            end
        end else begin
            if (en_a) begin
                r_a_vld <= i_in_valid;
            end
            if (en_b) begin
                r_b_vld <= r_a_vld;
                if (r_a_vld) begin
                    r_sum          <= n_sum;
                    r_array_stat   <= n_array_stat;
                    r_battery_stat <= n_battery_stat;
                end
            end
            if (en_o) begin
                r_o_vld <= r_b_vld;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_a_new <= w_new_set;
        end
        if (en_b && r_a_vld) begin
            r_b_avg          <= n_avg;
            r_b_array_stat   <= n_array_stat;
            r_b_battery_stat <= n_battery_stat;
        end
        if (en_o && r_b_vld) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_o_vld;
    assign o_out_item  = r_out;

`include "assert_macros.svh"

    `ASW_ASSERT(a_full_when_blocked, i_clk, i_rst_n, !o_in_ready |-> (r_a_vld && r_b_vld && r_o_vld), "input blocked with a free stage")
    `ASW_ASSERT(a_run_matches, i_clk, i_rst_n, o_out_valid |-> (o_out_item.pwm_enable == (o_out_item.array_good && o_out_item.battery_good)), "pwm enable disagrees with statuses")
    `ASW_ASSERT(a_state_hold, i_clk, i_rst_n, !(en_b && r_a_vld) |=> ($stable(r_array_stat) && $stable(r_battery_stat)), "status moved without an item")

endmodule

@@ tb/supply_monitor_checker.sv @@
// ---------------------------------------------------------------------------
// supply_monitor_checker
// Watches the sample and result channels of the supply monitor and keeps its
// own moving-average window and hysteresis statuses. It predicts one result
// per accepted sample set and compares every returned result, field by field,
// against the oldest prediction.
// ---------------------------------------------------------------------------
module supply_monitor_checker
    import asw_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  t_in_item             i_in_item,
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  t_out_item            i_out_item,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [REG_W-1:0]     i_cfg_data,
    output int                   o_mismatches,
    output int                   o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    t_sample          window_ring [DEPTH][CHANNELS];
    t_slot            next_slot;
    t_sum             chan_sum [CHANNELS];
    logic             arr_stat;
    logic             bat_stat;
    logic [REG_W-1:0] arr_on;
    logic [REG_W-1:0] arr_off;
    logic [REG_W-1:0] bat_on_lo;
    logic [REG_W-1:0] bat_on_hi;
    logic [REG_W-1:0] bat_off_lo;
    logic [REG_W-1:0] bat_off_hi;

    t_out_item expected_readings [$];
    int        mismatch_count = 0;
    int        pending_count  = 0;

    assign o_mismatches  = mismatch_count;
    assign o_outstanding = pending_count;

    // Push one set into the window and return the readings it yields.
    function automatic t_out_item average_and_supervise(input t_in_item set);
        t_sample   fresh [CHANNELS];
        t_avg      mean [CHANNELS];
        t_out_item r;
        logic      run;
        fresh[CH_ARRAY_V]   = set.array_voltage_sample;
        fresh[CH_ARRAY_I]   = set.array_current_sample;
        fresh[CH_BATTERY_V] = set.battery_voltage_sample;
        fresh[CH_BATTERY_I] = set.battery_current_sample;
        for (int c = 0; c < CHANNELS; c++) begin
            chan_sum[c] = chan_sum[c] - window_ring[next_slot][c] + fresh[c];
            window_ring[next_slot][c] = fresh[c];
            mean[c] = t_avg'(chan_sum[c] / DEPTH);
        end
        next_slot = next_slot + 1'b1;

        if (arr_stat) begin
            arr_stat = (mean[CH_ARRAY_V] >= arr_off);
        end else begin
            arr_stat = (mean[CH_ARRAY_V] >= arr_on);
        end
        if (bat_stat) begin
            bat_stat = (mean[CH_BATTERY_V] >= bat_off_lo) && (mean[CH_BATTERY_V] <= bat_off_hi);
        end else begin
            bat_stat = (mean[CH_BATTERY_V] >= bat_on_lo) && (mean[CH_BATTERY_V] <= bat_on_hi);
        end
        run = arr_stat && bat_stat;

        r.avg_array_voltage   = mean[CH_ARRAY_V];
        r.avg_array_current   = mean[CH_ARRAY_I];
        r.avg_battery_voltage = mean[CH_BATTERY_V];
        r.avg_battery_current = mean[CH_BATTERY_I];
        r.array_good          = arr_stat;
        r.battery_good        = bat_stat;
        r.fault_led           = !run;
        r.run_led             = run;
        r.pwm_enable          = run;
        r.input_power         = POWER_W'(mean[CH_ARRAY_I]) * POWER_W'(mean[CH_ARRAY_V]);
        return r;
    endfunction

    task automatic check_field(input string field, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < DEPTH; s++) begin
                for (int c = 0; c < CHANNELS; c++) begin
                    window_ring[s][c] = '0;
                end
            end
            for (int c = 0; c < CHANNELS; c++) begin
                chan_sum[c] = '0;
            end
            next_slot  = '0;
            arr_stat   = 1'b0;
            bat_stat   = 1'b0;
            arr_on     = RST_ARRAY_ON_LEVEL;
            arr_off    = RST_ARRAY_OFF_LEVEL;
            bat_on_lo  = RST_BATTERY_ON_LOW;
            bat_on_hi  = RST_BATTERY_ON_HIGH;
            bat_off_lo = RST_BATTERY_OFF_LOW;
            bat_off_hi = RST_BATTERY_OFF_HIGH;
            expected_readings.delete();
        end else begin
            // Spare indexes fall through and leave the thresholds alone.
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_ARRAY_ON_LEVEL:   arr_on     = i_cfg_data;
                    CFG_ARRAY_OFF_LEVEL:  arr_off    = i_cfg_data;
                    CFG_BATTERY_ON_LOW:   bat_on_lo  = i_cfg_data;
                    CFG_BATTERY_ON_HIGH:  bat_on_hi  = i_cfg_data;
                    CFG_BATTERY_OFF_LOW:  bat_off_lo = i_cfg_data;
                    CFG_BATTERY_OFF_HIGH: bat_off_hi = i_cfg_data;
                    default: ;
                endcase
            end

            if (i_out_valid && i_out_ready) begin
                if (expected_readings.size() == 0) begin
                    $error("result item with no prediction pending: %h", i_out_item);
                    mismatch_count++;
                end else begin
                    t_out_item want;
                    want = expected_readings.pop_front();
                    check_field("avg_array_voltage", want.avg_array_voltage,
                                i_out_item.avg_array_voltage);
                    check_field("avg_array_current", want.avg_array_current,
                                i_out_item.avg_array_current);
                    check_field("avg_battery_voltage", want.avg_battery_voltage,
                                i_out_item.avg_battery_voltage);
                    check_field("avg_battery_current", want.avg_battery_current,
                                i_out_item.avg_battery_current);
                    check_field("array_good", want.array_good, i_out_item.array_good);
                    check_field("battery_good", want.battery_good, i_out_item.battery_good);
                    check_field("fault_led", want.fault_led, i_out_item.fault_led);
                    check_field("run_led", want.run_led, i_out_item.run_led);
                    check_field("pwm_enable", want.pwm_enable, i_out_item.pwm_enable);
                    check_field("input_power", want.input_power, i_out_item.input_power);
                end
            end

            if (i_in_valid && i_in_ready) begin
                expected_readings.push_back(average_and_supervise(i_in_item));
            end
        end
        pending_count = expected_readings.size();
    end

endmodule

@@ tb/testbench.sv @@
// ---------------------------------------------------------------------------
// testbench
// Drives sample sets and threshold writes into the averaged supply window
// monitor under three idling regimes, with long output stalls and a full
// drain along the way. A checker beside the block predicts and compares every
// result; this module only makes stimulus and reports the verdict.
// ---------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import asw_pkg::*;

    // Spare register indexes; writes to them must have no effect.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    localparam int SAMPLE_MAX = (1 << SAMPLE_BITS) - 1;
    localparam int STALL_CYCLES = 50;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    t_in_item             in_item   = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    t_out_item            out_item;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_ARRAY_ON_LEVEL;
    logic [REG_W-1:0]     cfg_data  = '0;

    int mismatches;
    int outstanding;

    // Idling odds in percent, changed per regime by the stimulus process.
    int   send_gap_pct   = 11;
    int   recv_stall_pct = 59;
    logic hold_request   = 1'b0;

    // Last written thresholds; used only to steer voltages toward the bounds.
    logic [REG_W-1:0] threshold_shadow [8];
    int array_level   = 1000;
    int battery_level = 1000;

    always #5 clk = ~clk;

    averaged_supply_window_monitor_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    supply_monitor_checker checker_inst (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_in_item     (in_item),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_out_item    (out_item),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    function automatic t_in_item uniform_set(input logic [11:0] av, input logic [11:0] ai,
                                             input logic [11:0] bv, input logic [11:0] bi);
        t_in_item s;
        s.array_voltage_sample   = av;
        s.array_current_sample   = ai;
        s.battery_voltage_sample = bv;
        s.battery_current_sample = bi;
        return s;
    endfunction

    // Sample a little noise around a level, clipped to the ADC range.
    function automatic logic [11:0] scatter_around(input int level);
        int v;
        v = level + int'($urandom_range(160)) - 80;
        if (v < 0) begin
            v = 0;
        end else if (v > SAMPLE_MAX) begin
            v = SAMPLE_MAX;
        end
        return 12'(v);
    endfunction

    // Aim at one of two bounds most of the time, anywhere otherwise.
    function automatic int pick_level(input int bound_a, input int bound_b);
        case ($urandom_range(4))
            0, 1:    return bound_a;
            2, 3:    return bound_b;
            default: return int'($urandom_range(SAMPLE_MAX));
        endcase
    endfunction

    // Mostly voltages hovering near the thresholds so the hysteresis toggles;
    // the rest is full-range noise so every bit of every field moves.
    function automatic t_in_item make_set();
        t_in_item s;
        s = uniform_set(12'($urandom), 12'($urandom), 12'($urandom), 12'($urandom));
        if ($urandom_range(99) < 75) begin
            s.array_voltage_sample   = scatter_around(array_level);
            s.battery_voltage_sample = scatter_around(battery_level);
        end
        return s;
    endfunction

    // Offer one item: optional gap first, then hold valid and payload until
    // the block takes it. Leave valid high so back-to-back items need no dip.
    task automatic send_set(input t_in_item set);
        while ($urandom_range(99) < send_gap_pct) begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        in_item  = set;
        do begin
            @(posedge clk);
        end while (!in_ready);
        @(negedge clk);
    endtask

    // Drop valid and wait until every predicted result has come back.
    task automatic drain();
        in_valid = 1'b0;
        while (outstanding != 0) begin
            @(negedge clk);
        end
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] val);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        threshold_shadow[idx] = val;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic set_thresholds(input logic [REG_W-1:0] a_on, input logic [REG_W-1:0] a_off,
                                  input logic [REG_W-1:0] b_on_lo,
                                  input logic [REG_W-1:0] b_on_hi,
                                  input logic [REG_W-1:0] b_off_lo,
                                  input logic [REG_W-1:0] b_off_hi);
        write_reg(CFG_ARRAY_ON_LEVEL, a_on);
        write_reg(CFG_ARRAY_OFF_LEVEL, a_off);
        write_reg(CFG_BATTERY_ON_LOW, b_on_lo);
        write_reg(CFG_BATTERY_ON_HIGH, b_on_hi);
        write_reg(CFG_BATTERY_OFF_LOW, b_off_lo);
        write_reg(CFG_BATTERY_OFF_HIGH, b_off_hi);
    endtask

    // Random sets with drifting voltage targets. Optionally request a long
    // output stall, or pause until the block is empty, at a given item.
    task automatic run_random(input int count, input int hold_at, input int pause_at);
        for (int k = 0; k < count; k++) begin
            if (k == hold_at) begin
                hold_request = 1'b1;
            end
            if (k == pause_at) begin
                drain();
            end
            if ($urandom_range(99) < 6) begin
                array_level = pick_level(threshold_shadow[CFG_ARRAY_ON_LEVEL],
                                         threshold_shadow[CFG_ARRAY_OFF_LEVEL]);
            end
            if ($urandom_range(99) < 6) begin
                battery_level = pick_level(threshold_shadow[$urandom_range(2, 3)],
                                           threshold_shadow[$urandom_range(4, 5)]);
            end
            send_set(make_set());
        end
    endtask

    // Receiver: random stalls, plus one long hold-off counted here whenever
    // the stimulus asks for it, so the pipeline fills and blocks its input.
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(negedge clk);
            if (stall_left > 0) begin
                out_ready = 1'b0;
                stall_left--;
            end else if (hold_request) begin
                hold_request = 1'b0;
                stall_left   = STALL_CYCLES - 1;
                out_ready    = 1'b0;
            end else begin
                out_ready = ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    initial begin
        int lo;
        int on_lo;
        int on_hi;
        int hi;
        int a_off;

        threshold_shadow[CFG_ARRAY_ON_LEVEL]   = RST_ARRAY_ON_LEVEL;
        threshold_shadow[CFG_ARRAY_OFF_LEVEL]  = RST_ARRAY_OFF_LEVEL;
        threshold_shadow[CFG_BATTERY_ON_LOW]   = RST_BATTERY_ON_LOW;
        threshold_shadow[CFG_BATTERY_ON_HIGH]  = RST_BATTERY_ON_HIGH;
        threshold_shadow[CFG_BATTERY_OFF_LOW]  = RST_BATTERY_OFF_LOW;
        threshold_shadow[CFG_BATTERY_OFF_HIGH] = RST_BATTERY_OFF_HIGH;

        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        // Defaults written explicitly, then spare indexes with junk that a
        // misdecoded index would spread into a real threshold.
        set_thresholds(RST_ARRAY_ON_LEVEL, RST_ARRAY_OFF_LEVEL, RST_BATTERY_ON_LOW,
                       RST_BATTERY_ON_HIGH, RST_BATTERY_OFF_LOW, RST_BATTERY_OFF_HIGH);
        write_reg(CFG_SPARE_LO, 12'hFFF);
        write_reg(CFG_SPARE_HI, 12'h000);

        // Field extremes and alternating bit patterns.
        send_set(uniform_set(12'h000, 12'h000, 12'h000, 12'h000));
        send_set(uniform_set(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF));
        send_set(uniform_set(12'hAAA, 12'h555, 12'hAAA, 12'h555));
        send_set(uniform_set(12'h555, 12'hAAA, 12'h555, 12'hAAA));
        // Settle both voltages inside their windows until the run LED lights.
        repeat (14) send_set(uniform_set(12'd1600, 12'd2000, 12'd1000, 12'd300));

        // Both battery windows inverted: an ok battery fails at once and a
        // failed one can never recover.
        drain();
        set_thresholds(RST_ARRAY_ON_LEVEL, RST_ARRAY_OFF_LEVEL, 12'd3000, 12'd100,
                       12'd2000, 12'd100);
        repeat (4) send_set(uniform_set(12'd1600, 12'd2000, 12'd1000, 12'd300));

        // Wide-open on window with inverted off window: the battery toggles.
        drain();
        set_thresholds(RST_ARRAY_ON_LEVEL, RST_ARRAY_OFF_LEVEL, 12'd0, 12'hFFF,
                       12'd2000, 12'd100);
        repeat (4) send_set(uniform_set(12'd1600, 12'd2000, 12'd1000, 12'd300));

        // Regime one: sender mostly busy, receiver stalls often.
        drain();
        set_thresholds(RST_ARRAY_ON_LEVEL, RST_ARRAY_OFF_LEVEL, RST_BATTERY_ON_LOW,
                       RST_BATTERY_ON_HIGH, RST_BATTERY_OFF_LOW, RST_BATTERY_OFF_HIGH);
        run_random(100, -1, -1);
        drain();
        set_thresholds('0, '0, '0, '0, '0, '0);
        run_random(40, -1, -1);
        drain();
        set_thresholds('1, '1, '1, '1, '1, '1);
        run_random(40, -1, -1);

        // Regime two: sender idles often, receiver mostly ready; one long
        // output stall while items keep coming.
        drain();
        send_gap_pct   = 59;
        recv_stall_pct = 11;
        a_off = $urandom_range(2500);
        lo    = $urandom_range(1500);
        on_lo = lo + $urandom_range(200);
        on_hi = on_lo + $urandom_range(2000);
        hi    = (on_hi + $urandom_range(200) > SAMPLE_MAX) ? SAMPLE_MAX
                                                           : on_hi + $urandom_range(200);
        set_thresholds(12'(a_off + $urandom_range(500)), 12'(a_off), 12'(on_lo),
                       12'(on_hi), 12'(lo), 12'(hi));
        run_random(120, 60, -1);
        drain();
        // Fully random thresholds: inverted windows are common here.
        set_thresholds(12'($urandom), 12'($urandom), 12'($urandom), 12'($urandom),
                       12'($urandom), 12'($urandom));
        run_random(60, -1, -1);

        // Regime three: no idling on either side; stall early, pause midway.
        drain();
        send_gap_pct   = 0;
        recv_stall_pct = 0;
        a_off = $urandom_range(2500);
        lo    = $urandom_range(1500);
        on_lo = lo + $urandom_range(200);
        on_hi = on_lo + $urandom_range(2000);
        hi    = (on_hi + $urandom_range(200) > SAMPLE_MAX) ? SAMPLE_MAX
                                                           : on_hi + $urandom_range(200);
        set_thresholds(12'(a_off + $urandom_range(500)), 12'(a_off), 12'(on_lo),
                       12'(on_hi), 12'(lo), 12'(hi));
        run_random(130, 10, 70);
        drain();
        set_thresholds(RST_ARRAY_ON_LEVEL, RST_ARRAY_OFF_LEVEL, RST_BATTERY_ON_LOW,
                       RST_BATTERY_ON_HIGH, RST_BATTERY_OFF_LOW, RST_BATTERY_OFF_HIGH);
        run_random(60, -1, -1);

        // Wait out the pipeline, then a few more cycles to catch strays.
        drain();
        repeat (8) @(negedge clk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Guard against a hung handshake.
    initial begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

@@ averaged_supply_window_monitor_unit.f @@
+incdir+sv
sv/asw_pkg.sv
sv/asw_ring.sv
sv/averaged_supply_window_monitor_unit.sv
tb/supply_monitor_checker.sv
tb/testbench.sv
